/* design/spct_pkg.sv */
// ----------------------------------------------------------------------------
// spct_pkg
// Shared widths, pair selector codes and verdict codes for the shape pair
// collision test.
// ----------------------------------------------------------------------------
`default_nettype none

package spct_pkg;

	// Coordinate width, signed Q8.8 at the default value
	localparam int COORD_BITS = 16;
	localparam int RADIUS_BITS = COORD_BITS - 1;
	localparam int FUNC_BITS = 4;

	// Tolerance register
	localparam int EPS_BITS = 8;
	localparam int EPS_SHIFT = 8;
	localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

	// Pair selector: 3*first_kind + second_kind (point 0, circle 1, box 2)
	localparam logic [FUNC_BITS-1:0] FUNC_PT_PT = 4'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_PT_CIR = 4'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_PT_BOX = 4'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_CIR_PT = 4'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_CIR_CIR = 4'd4;
	localparam logic [FUNC_BITS-1:0] FUNC_CIR_BOX = 4'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_BOX_PT = 4'd6;
	localparam logic [FUNC_BITS-1:0] FUNC_BOX_CIR = 4'd7;
	localparam logic [FUNC_BITS-1:0] FUNC_BOX_BOX = 4'd8;

	typedef enum logic [1:0] {
		VERDICT_MISS       = 2'd0,
		VERDICT_HIT        = 2'd1,
		VERDICT_UNRESOLVED = 2'd2
	} verdict_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [RADIUS_BITS-1:0] radius_t;

endpackage

`default_nettype wire

/* design/spct_if.sv */
// ----------------------------------------------------------------------------
// spct_if
// Valid/ready channels of the shape pair collision test: the shape pair
// channel and the verdict channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface spct_pair_if;
	logic valid;
	logic ready;
	logic [spct_pkg::FUNC_BITS-1:0] func;
	spct_pkg::coord_t first_x0;
	spct_pkg::coord_t first_y0;
	spct_pkg::coord_t first_x1;
	spct_pkg::coord_t first_y1;
	spct_pkg::radius_t first_radius;
	spct_pkg::coord_t second_x0;
	spct_pkg::coord_t second_y0;
	spct_pkg::coord_t second_x1;
	spct_pkg::coord_t second_y1;
	spct_pkg::radius_t second_radius;

	modport source (
		output valid, func, first_x0, first_y0, first_x1, first_y1, first_radius,
		output second_x0, second_y0, second_x1, second_y1, second_radius,
		input ready
	);
	modport sink (
		input valid, func, first_x0, first_y0, first_x1, first_y1, first_radius,
		input second_x0, second_y0, second_x1, second_y1, second_radius,
		output ready
	);
endinterface

interface spct_result_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

`default_nettype wire

/* design/shape_pair_collision_test.sv */
// ----------------------------------------------------------------------------
// shape_pair_collision_test
// Collision test for one pair of 2D shapes (point, circle, axis-aligned box).
// ----------------------------------------------------------------------------
// Usage:
//   pair_in  - valid/ready channel carrying the selector func and both shapes
//              in signed Q8.8 coordinates; a transfer happens when valid and
//              ready are high at a rising clk edge.
//   result   - valid/ready channel carrying one 2-bit verdict per pair:
//              0 no collision, 1 collision, 2 unresolved pair order or unused selector.
//   cfg_we / cfg_wdata - write the epsilon tolerance (Q8.8 units); write it
//              only while no pair is in flight.
// Pipeline: input register, operand stage (clamp, differences, box
// compares), then the squaring logic that loads the verdict register.
// Throughput is one pair per cycle while the receiver does not stall; the
// squaring logic with its three parallel 16x16 multipliers sets the cycle
// time. Each stage holds its
// own valid bit and accepts new data when empty or when it drains, so
// bubbles close up while the receiver stalls; a stalled verdict holds until
// taken and pair_in.ready drops only once every stage is full. arst_n clears
// all valid bits and sets epsilon to 1; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module shape_pair_collision_test (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	spct_pair_if.sink                          pair_in,
	spct_result_if.source                      result,
	input  wire logic                          cfg_we,
	input  wire logic [spct_pkg::EPS_BITS-1:0] cfg_wdata
);

	localparam int CW = spct_pkg::COORD_BITS;
	localparam int DIFF_W = CW + 1;
	localparam int BOX_W = ((CW > spct_pkg::EPS_BITS) ? CW : spct_pkg::EPS_BITS) + 2;
	localparam int SQ_W = 2 * CW;
	localparam int LIM_W = 2 * CW + 1;

	// Clamp v into [lo, hi]; on an inverted box the lower bound is taken only when v is below it, else the upper bound.
	function automatic spct_pkg::coord_t clamp_coord(
		input spct_pkg::coord_t v,
		input spct_pkg::coord_t lo,
		input spct_pkg::coord_t hi
	);
		spct_pkg::coord_t r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Magnitude of the difference of two coordinates; fits in CW bits.
	function automatic logic [CW-1:0] abs_diff(
		input spct_pkg::coord_t a,
		input spct_pkg::coord_t b
	);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(a) - DIFF_W'(b);
		if (d < 0) begin
			d = -d;
		end
		return d[CW-1:0];
	endfunction

	// Tolerance register
	logic [spct_pkg::EPS_BITS-1:0] epsilon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= spct_pkg::EPS_RESET;
		end else if (cfg_we) begin
			epsilon_q <= cfg_wdata;
		end
	end

	// Stage handshake: a stage loads when empty or when it drains this cycle
	logic valid_s1, valid_s2, out_valid_q;
	logic adv_s1, adv_s2, adv_out;

	assign adv_out = !out_valid_q || result.ready;
	assign adv_s2 = !valid_s2 || adv_out;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pair_in.ready = adv_s1;

	// Stage 1: input register
	logic [spct_pkg::FUNC_BITS-1:0] func_s1;
	spct_pkg::coord_t ax0_s1, ay0_s1, ax1_s1, ay1_s1;
	spct_pkg::coord_t bx0_s1, by0_s1, bx1_s1, by1_s1;
	spct_pkg::radius_t ar_s1, br_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pair_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pair_in.valid) begin
			func_s1 <= pair_in.func;
			ax0_s1  <= pair_in.first_x0;
			ay0_s1  <= pair_in.first_y0;
			ax1_s1  <= pair_in.first_x1;
			ay1_s1  <= pair_in.first_y1;
			ar_s1   <= pair_in.first_radius;
			bx0_s1  <= pair_in.second_x0;
			by0_s1  <= pair_in.second_y0;
			bx1_s1  <= pair_in.second_x1;
			by1_s1  <= pair_in.second_y1;
			br_s1   <= pair_in.second_radius;
		end
	end

	// Stage 2: pick the two points and the reach of a distance test, or
	// settle the verdict right away for box overlaps and fixed answers.
	logic signed [BOX_W-1:0] eps_w;
	logic signed [BOX_W-1:0] ax0_w, ay0_w, ax1_w, ay1_w;
	logic signed [BOX_W-1:0] bx0_w, by0_w, bx1_w, by1_w;
	logic pt_in_box, box_overlap;
	spct_pkg::coord_t px, py, qx, qy;
	logic [CW-1:0] reach_d;
	logic use_dist_d;
	spct_pkg::verdict_t fixed_d;

	assign eps_w = BOX_W'(epsilon_q);
	assign ax0_w = BOX_W'(ax0_s1);
	assign ay0_w = BOX_W'(ay0_s1);
	assign ax1_w = BOX_W'(ax1_s1);
	assign ay1_w = BOX_W'(ay1_s1);
	assign bx0_w = BOX_W'(bx0_s1);
	assign by0_w = BOX_W'(by0_s1);
	assign bx1_w = BOX_W'(bx1_s1);
	assign by1_w = BOX_W'(by1_s1);

	// First point strictly inside the second box shrunk by epsilon
	assign pt_in_box = (ax0_w + eps_w < bx1_w) && (ay0_w + eps_w < by1_w)
		&& (ax0_w - eps_w > bx0_w) && (ay0_w - eps_w > by0_w);
	// Epsilon-margined strict overlap of the two boxes
	assign box_overlap = (bx0_w + eps_w < ax1_w) && (by0_w + eps_w < ay1_w)
		&& (bx1_w - eps_w > ax0_w) && (by1_w - eps_w > ay0_w);

	always_comb begin
		px = ax0_s1;
		py = ay0_s1;
		qx = bx0_s1;
		qy = by0_s1;
		reach_d = CW'(ar_s1);
		use_dist_d = 1'b0;
		fixed_d = spct_pkg::VERDICT_UNRESOLVED;
		unique case (func_s1)
			spct_pkg::FUNC_PT_PT: begin
				fixed_d = spct_pkg::VERDICT_MISS;
			end
			spct_pkg::FUNC_PT_CIR: begin
				reach_d = CW'(br_s1);
				use_dist_d = 1'b1;
			end
			spct_pkg::FUNC_PT_BOX: begin
				fixed_d = pt_in_box ? spct_pkg::VERDICT_HIT : spct_pkg::VERDICT_MISS;
			end
			spct_pkg::FUNC_CIR_CIR: begin
				reach_d = CW'(ar_s1) + CW'(br_s1);
				use_dist_d = 1'b1;
			end
			spct_pkg::FUNC_CIR_BOX: begin
				px = clamp_coord(ax0_s1, bx0_s1, bx1_s1);
				py = clamp_coord(ay0_s1, by0_s1, by1_s1);
				qx = ax0_s1;
				qy = ay0_s1;
				use_dist_d = 1'b1;
			end
			spct_pkg::FUNC_BOX_CIR: begin
				px = clamp_coord(bx0_s1, ax0_s1, ax1_s1);
				py = clamp_coord(by0_s1, ay0_s1, ay1_s1);
				qx = bx0_s1;
				qy = by0_s1;
				reach_d = CW'(br_s1);
				use_dist_d = 1'b1;
			end
			spct_pkg::FUNC_BOX_BOX: begin
				fixed_d = box_overlap ? spct_pkg::VERDICT_HIT : spct_pkg::VERDICT_MISS;
			end
			default: begin
				// circle-point, box-point and unused selectors
				fixed_d = spct_pkg::VERDICT_UNRESOLVED;
			end
		endcase
	end

	logic [CW-1:0] dx_s2, dy_s2, reach_s2;
	logic use_dist_s2;
	spct_pkg::verdict_t fixed_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dx_s2       <= abs_diff(px, qx);
			dy_s2       <= abs_diff(py, qy);
			reach_s2    <= reach_d;
			use_dist_s2 <= use_dist_d;
			fixed_s2    <= fixed_d;
		end
	end

	// Stage 3: squared distance against squared reach plus epsilon at Q16.16
	logic [SQ_W-1:0] dx_sq, dy_sq, reach_sq;
	logic [LIM_W-1:0] dist_sq, limit_sq;
	spct_pkg::verdict_t verdict_d;

	assign dx_sq = SQ_W'(dx_s2) * SQ_W'(dx_s2);
	assign dy_sq = SQ_W'(dy_s2) * SQ_W'(dy_s2);
	assign reach_sq = SQ_W'(reach_s2) * SQ_W'(reach_s2);
	assign dist_sq = LIM_W'(dx_sq) + LIM_W'(dy_sq);
	assign limit_sq = LIM_W'(reach_sq) + (LIM_W'(epsilon_q) << spct_pkg::EPS_SHIFT);

	always_comb begin
		if (use_dist_s2) begin
			verdict_d = (dist_sq <= limit_sq) ? spct_pkg::VERDICT_HIT : spct_pkg::VERDICT_MISS;
		end else begin
			verdict_d = fixed_s2;
		end
	end

	// Verdict register; holds while the receiver stalls
	spct_pkg::verdict_t verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			verdict_q <= verdict_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.verdict = verdict_q;

endmodule

`default_nettype wire

/* design/spct_checker.sv */
// ----------------------------------------------------------------------------
// spct_checker
// Port-level checks of the shape pair collision test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spct_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [spct_pkg::FUNC_BITS-1:0] in_func,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [1:0]                     out_verdict
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// A stalled verdict holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_verdict))
		else $error("verdict changed while stalled");

	// Only the three defined verdict codes appear
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_verdict == spct_pkg::VERDICT_MISS
			|| out_verdict == spct_pkg::VERDICT_HIT
			|| out_verdict == spct_pkg::VERDICT_UNRESOLVED))
		else $error("undefined verdict code");

	// A point-point pair emerges from the verdict register as no collision when
	// there is no reset and an open receiver while it passes the stages in between
	a_pt_pt_miss: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_xfer && in_func == spct_pkg::FUNC_PT_PT, 3)
		&& $past(arst_n, 1) && $past(arst_n, 2)
		&& $past(out_ready, 1) && $past(out_ready, 2)
		|-> out_valid && out_verdict == spct_pkg::VERDICT_MISS)
		else $error("point-point pair not reported as no collision");

	// An unused selector emerges from the verdict register as unresolved, given no reset and an open receiver
	a_unused_func: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_xfer && in_func > spct_pkg::FUNC_BOX_BOX, 3)
		&& $past(arst_n, 1) && $past(arst_n, 2)
		&& $past(out_ready, 1) && $past(out_ready, 2)
		|-> out_valid && out_verdict == spct_pkg::VERDICT_UNRESOLVED)
		else $error("unused selector not reported as unresolved");

endmodule

bind shape_pair_collision_test spct_checker u_spct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pair_in.valid),
	.in_ready    (pair_in.ready),
	.in_func     (pair_in.func),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_verdict (result.verdict)
);

`default_nettype wire
